### hdl/b2da_pkg.sv
// b2da_pkg: shared types, constants and functions of the binary to decimal
// ascii converter. No dependencies.
package b2da_pkg;

  localparam int unsigned NumDigits = 5;
  localparam int unsigned InWidth   = 16;
  localparam int unsigned BcdWidth  = 4 * NumDigits;
  localparam int unsigned CharWidth = 6;
  localparam int unsigned CntWidth  = $clog2(NumDigits + 1);

  localparam logic [CharWidth-1:0] CharZero = 6'd48;

  typedef struct packed {
    logic [BcdWidth-1:0] bcd;
    logic [InWidth-1:0]  bin;
  } dd_word_t;

  function automatic logic [CharWidth-1:0] to_char(input logic [3:0] digit);
    return CharZero + {2'b00, digit};
  endfunction

endpackage

### hdl/binary_to_decimal_ascii_core.sv
// binary_to_decimal_ascii_core: top level of the binary to decimal ascii
// converter. Depends on b2da_pkg, b2da_dabble_cell and b2da_serializer.
//
// Usage:
//   A transaction is accepted at a rising edge with start high and busy low;
//   value_i is the unsigned 16-bit number to print.
//   Five characters follow on digit_char_o, ten-thousands digit first with
//   leading zeros, each valid for one cycle while strobe is high. last_o
//   marks the units digit.
//   The number passes a chain of 16 double dabble cells, one bit per cell,
//   then a five-entry digit shift register.
//   The first character reaches the ports once the value has passed every
//   cell of the chain and been loaded into the serializer; the units
//   character is the last of the five that follow.
//   Accepts are spaced by busy so that the serializer, emitting one
//   character per cycle, ends each value before the next one loads; busy
//   is high after each accept and falls while earlier values are still moving down the chain.
//   Reset clears the valid bits of the chain, the busy counter and the
//   character counter; values in flight are dropped.
//   The receiver cannot stall: characters are sent whether taken or not.
module binary_to_decimal_ascii_core import b2da_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  logic [InWidth-1:0]   value_i,
  output logic                 strobe,
  output logic [CharWidth-1:0] digit_char_o,
  output logic                 last_o
);

  localparam logic [CntWidth-1:0] BusyCycles = CntWidth'(NumDigits - 1);

  logic                accept;
  logic [CntWidth-1:0] busy_cnt_q, busy_cnt_d;
  logic                valid_w [InWidth+1];
  dd_word_t            data_w  [InWidth+1];

  assign accept = start && !busy;
  assign busy   = (busy_cnt_q != '0);

  always_comb begin
    if (accept) begin
      busy_cnt_d = BusyCycles;
    end else if (busy_cnt_q != '0) begin
      busy_cnt_d = busy_cnt_q - 1'b1;
    end else begin
      busy_cnt_d = busy_cnt_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_cnt_q <= '0;
    end else begin
      busy_cnt_q <= busy_cnt_d;
    end
  end

  assign valid_w[0]    = accept;
  assign data_w[0].bcd = '0;
  assign data_w[0].bin = value_i;

  for (genvar g = 0; g < InWidth; g++) begin : g_cell
    b2da_dabble_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (valid_w[g]),
      .data_i  (data_w[g]),
      .valid_o (valid_w[g+1]),
      .data_o  (data_w[g+1])
    );
  end

  b2da_serializer u_ser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (valid_w[InWidth]),
    .bcd_i        (data_w[InWidth].bcd),
    .strobe_o     (strobe),
    .digit_char_o (digit_char_o),
    .last_o       (last_o)
  );

  // first character appears after the chain and serializer load
  a_first_char: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> ##16 (strobe && !last_o))
    else $error("first character missing after accept");

  a_last_char: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> ##20 (strobe && last_o))
    else $error("units character missing after accept");

  a_last_strobed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_o |-> strobe)
    else $error("last without strobe");

  a_no_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe && !last_o) |=> strobe)
    else $error("gap inside a transaction");

  a_accept_spacing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy)
    else $error("busy not raised after accept");

endmodule

### hdl/b2da_dabble_cell.sv
// b2da_dabble_cell: one shift-and-add-3 step of the double dabble chain,
// registered. Depends on b2da_pkg.
module b2da_dabble_cell import b2da_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     valid_i,
  input  dd_word_t data_i,
  output logic     valid_o,
  output dd_word_t data_o
);

  logic     valid_q;
  dd_word_t data_q, data_d;
  logic [BcdWidth-1:0] adj;

  always_comb begin
    for (int i = 0; i < NumDigits; i++) begin
      if (data_i.bcd[4*i +: 4] >= 4'd5) begin
        adj[4*i +: 4] = data_i.bcd[4*i +: 4] + 4'd3;
      end else begin
        adj[4*i +: 4] = data_i.bcd[4*i +: 4];
      end
    end
    data_d.bcd = {adj[BcdWidth-2:0], data_i.bin[InWidth-1]};
    data_d.bin = {data_i.bin[InWidth-2:0], 1'b0};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

### hdl/b2da_serializer.sv
// b2da_serializer: row of digit registers that shifts one ascii character out
// per cycle, most significant first. Depends on b2da_pkg.
module b2da_serializer import b2da_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 load_i,
  input  logic [BcdWidth-1:0]  bcd_i,
  output logic                 strobe_o,
  output logic [CharWidth-1:0] digit_char_o,
  output logic                 last_o
);

  localparam logic [CntWidth-1:0] FullCnt = CntWidth'(NumDigits);

  logic [3:0]          digits_q [NumDigits];
  logic [CntWidth-1:0] cnt_q, cnt_d;

  always_comb begin
    if (load_i) begin
      cnt_d = FullCnt;
    end else if (cnt_q != '0) begin
      cnt_d = cnt_q - 1'b1;
    end else begin
      cnt_d = cnt_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      for (int i = 0; i < NumDigits; i++) begin
        digits_q[i] <= bcd_i[BcdWidth-1-4*i -: 4];
      end
    end else begin
      for (int i = 0; i < NumDigits - 1; i++) begin
        digits_q[i] <= digits_q[i+1];
      end
    end
  end

  assign strobe_o     = (cnt_q != '0);
  assign last_o       = (cnt_q == CntWidth'(1));
  assign digit_char_o = to_char(digits_q[0]);

endmodule
